### design/handheld_console_timer_unit_assert.svh
// Assertion macros for the handheld console timer unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef HANDHELD_CONSOLE_TIMER_UNIT_ASSERT_SVH
`define HANDHELD_CONSOLE_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define HCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hct_pkg.sv
// Shared types, register addresses and a lookup function for the timer unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hct_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } hct_mode_t;

  localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
  localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
  localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
  localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

  localparam int unsigned CTRL_RUN_BIT = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  tick_count;
  } hct_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_interrupt;
  } hct_out_t;

  // prescale threshold per speed select
  function automatic logic [7:0] hct_threshold(input logic [1:0] speed);
    logic [7:0] lim;
    case (speed)
      2'd0:    lim = 8'd64;
      2'd1:    lim = 8'd1;
      2'd2:    lim = 8'd4;
      default: lim = 8'd16;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

### design/handheld_console_timer_unit.sv
// Handheld console timer unit: divider, counter, modulo and control registers.
// An input transfer is registered in stage 1 and then moves into the result
// register, where its result is valid; a stalled, full result register holds it.
// Throughput: one item per cycle; only a stalled, full result register stops it.
// Reset (rst_n low, synchronous): pipeline empties, all timer state clears.
// Depends on hct_pkg and handheld_console_timer_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

module handheld_console_timer_unit import hct_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire hct_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output hct_out_t     out_data
);

  // ---------------------------------------------------------------------
  // Pipeline control. Stage 1 is the input register; the item in it is
  // applied to the timer state in the cycle it moves into the result
  // register, so state updates happen in transfer order.
  // ---------------------------------------------------------------------
  logic     s1_valid_r, s1_valid_nxt;
  hct_in_t  s1_data_r;
  logic     s1_adv;
  logic     out_valid_r, out_valid_nxt;
  hct_out_t out_data_r, out_data_nxt;

  // Stage 1 drains when the result register is empty or being taken.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  assign s1_valid_nxt  = (in_valid && !in_stall) || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Timer state
  // ---------------------------------------------------------------------
  logic [1:0] quarter_r,  quarter_nxt;    // leftover machine cycles (div-by-4)
  logic [3:0] subcount_r, subcount_nxt;   // quarters toward next divider step
  logic [7:0] prescale_r, prescale_nxt;   // wrapping prescale count
  logic [7:0] divider_r,  divider_nxt;
  logic [7:0] counter_r,  counter_nxt;
  logic [7:0] modulo_r,   modulo_nxt;
  logic [7:0] control_r,  control_nxt;

  // ---------------------------------------------------------------------
  // Single-pass update: a tick is one 9-bit add, four 8-bit adds and two
  // compares; reads and writes are an address decode.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [8:0] total;
    logic [6:0] quarters;
    logic [7:0] prescale_sum;
    logic [7:0] sub_sum;
    logic [7:0] counter_inc;
    logic [7:0] limit;

    total        = 9'(quarter_r) + 9'(s1_data_r.tick_count);
    quarters     = total[8:2];
    prescale_sum = prescale_r + 8'(quarters);
    sub_sum      = 8'(subcount_r) + 8'(quarters);
    counter_inc  = counter_r + 8'd1;
    limit        = hct_threshold(control_r[1:0]);

    quarter_nxt  = quarter_r;
    subcount_nxt = subcount_r;
    prescale_nxt = prescale_r;
    divider_nxt  = divider_r;
    counter_nxt  = counter_r;
    modulo_nxt   = modulo_r;
    control_nxt  = control_r;
    out_data_nxt = '0;

    if (s1_adv) begin
      case (s1_data_r.mode)
        MODE_TICK: begin
          quarter_nxt  = total[1:0];
          subcount_nxt = sub_sum[3:0];
          divider_nxt  = divider_r + 8'(sub_sum[7:4]);
          prescale_nxt = prescale_sum;
          // counter steps at most once per tick
          if (control_r[CTRL_RUN_BIT] && (prescale_sum >= limit)) begin
            prescale_nxt = '0;
            if (counter_inc == 8'd0) begin
              counter_nxt                  = modulo_r;
              out_data_nxt.timer_interrupt = 1'b1;
            end else begin
              counter_nxt = counter_inc;
            end
          end
        end
        MODE_READ: begin
          case (s1_data_r.address)
            ADDR_DIVIDER: out_data_nxt.read_data = divider_r;
            ADDR_COUNTER: out_data_nxt.read_data = counter_r;
            ADDR_MODULO:  out_data_nxt.read_data = modulo_r;
            ADDR_CONTROL: out_data_nxt.read_data = control_r;
            default:      out_data_nxt.read_data = '0;
          endcase
        end
        MODE_WRITE: begin
          // divider write stores the byte; internal counts untouched
          case (s1_data_r.address)
            ADDR_DIVIDER: divider_nxt = s1_data_r.write_data;
            ADDR_COUNTER: counter_nxt = s1_data_r.write_data;
            ADDR_MODULO:  modulo_nxt  = s1_data_r.write_data;
            ADDR_CONTROL: control_nxt = s1_data_r.write_data;
            default: ;
          endcase
        end
        default: ;  // unused mode: no effect, zero result
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      quarter_r   <= '0;
      subcount_r  <= '0;
      prescale_r  <= '0;
      divider_r   <= '0;
      counter_r   <= '0;
      modulo_r    <= '0;
      control_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      quarter_r   <= quarter_nxt;
      subcount_r  <= subcount_nxt;
      prescale_r  <= prescale_nxt;
      divider_r   <= divider_nxt;
      counter_r   <= counter_nxt;
      modulo_r    <= modulo_nxt;
      control_r   <= control_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic irq_fire, irq_reload_ok, stopped_tick;

  assign irq_fire      = s1_adv && out_data_nxt.timer_interrupt;
  assign irq_reload_ok = out_data_r.timer_interrupt && (counter_r == modulo_r);
  assign stopped_tick  = s1_adv && (s1_data_r.mode == MODE_TICK) && !control_r[CTRL_RUN_BIT];

  `include "handheld_console_timer_unit_assert.svh"

  `HCT_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r, "stall with room")
  `HCT_ASSERT_NEXT(a_irq_reloads, irq_fire, irq_reload_ok, "interrupt without reload")
  `HCT_ASSERT_NEXT(a_stopped_counter_holds, stopped_tick, $stable(counter_r), "counter not held")

endmodule

`default_nettype wire

### tb/handheld_console_timer_unit_test.sv
// Testbench for handheld_console_timer_unit: a directed table, then random
// tick/read/write traffic, checked against an in-bench timer predictor.
// Depends on hct_pkg and the handheld_console_timer_unit RTL.
`timescale 1ns / 1ps

module handheld_console_timer_unit_test;
  import hct_pkg::*;

  // Mode 3 has no member in hct_mode_t; the block must treat it as a no-op.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned IDLE_PCT = 22;
  localparam int unsigned RANDOM_ITEMS = 2000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hct_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  hct_out_t out_data;

  handheld_console_timer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One row of the directed table. A pinned row carries its own expected
  // result; the others take the predictor's.
  typedef struct {
    hct_in_t  item;
    bit       pinned;
    hct_out_t res;
  } stim_row_t;

  stim_row_t directed_rows[$];
  hct_out_t  pending_results[$];   // expected results, oldest first
  int        mismatch_count = 0;
  bit        quiet = 1'b0;         // high: neither side idles

  // Pinned expectation for the transfer currently on the input port.
  bit        cur_pinned = 1'b0;
  hct_out_t  cur_pinned_res = '0;

  // Shadow copy of the timer state.
  logic [1:0] shadow_residue;
  logic [3:0] shadow_subcount;
  logic [7:0] shadow_prescale;
  logic [7:0] shadow_divider;
  logic [7:0] shadow_counter;
  logic [7:0] shadow_modulo;
  logic [7:0] shadow_control;

  hct_out_t want_res;
  hct_out_t model_res;

  // Advances the shadow state by one item and returns its result.
  function automatic hct_out_t timer_predict(input hct_in_t item);
    hct_out_t   res;
    logic [8:0] total;
    logic [6:0] quarters;
    logic [7:0] sub;
    logic [7:0] limit;
    res = '0;
    case (item.mode)
      MODE_TICK: begin
        // divide-by-4 stage, then prescale and divider both see the quarters
        total = 9'(shadow_residue) + 9'(item.tick_count);
        quarters = total[8:2];
        shadow_residue = total[1:0];
        shadow_prescale = shadow_prescale + 8'(quarters);
        sub = 8'(shadow_subcount) + 8'(quarters);
        shadow_divider = shadow_divider + 8'(sub[7:4]);
        shadow_subcount = sub[3:0];
        // threshold check happens once per tick while running, even for zero cycles
        if (shadow_control[CTRL_RUN_BIT]) begin
          case (shadow_control[1:0])
            2'd0:    limit = 8'd64;
            2'd1:    limit = 8'd1;
            2'd2:    limit = 8'd4;
            default: limit = 8'd16;
          endcase
          if (shadow_prescale >= limit) begin
            shadow_prescale = 8'd0;
            shadow_counter = shadow_counter + 8'd1;
            if (shadow_counter == 8'd0) begin
              shadow_counter = shadow_modulo;
              res.timer_interrupt = 1'b1;
            end
          end
        end
      end
      MODE_READ: begin
        case (item.address)
          ADDR_DIVIDER: res.read_data = shadow_divider;
          ADDR_COUNTER: res.read_data = shadow_counter;
          ADDR_MODULO:  res.read_data = shadow_modulo;
          ADDR_CONTROL: res.read_data = shadow_control;
          default:      res.read_data = 8'd0;
        endcase
      end
      MODE_WRITE: begin
        // divider write stores the byte; internal subcounts are untouched
        case (item.address)
          ADDR_DIVIDER: shadow_divider = item.write_data;
          ADDR_COUNTER: shadow_counter = item.write_data;
          ADDR_MODULO:  shadow_modulo = item.write_data;
          ADDR_CONTROL: shadow_control = item.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly ticks and mapped register accesses, biased so that the counter
  // runs and overflows often; a few unmapped addresses and unused modes.
  function automatic hct_in_t random_item();
    hct_in_t     item;
    int unsigned pick;
    item.mode = MODE_TICK;
    item.address = 16'($urandom_range(16'hFFFF));
    item.write_data = 8'($urandom_range(255));
    item.tick_count = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 50) begin
      item.mode = MODE_TICK;
      if ($urandom_range(99) < 65) item.tick_count = 8'($urandom_range(16));
    end else if (pick < 97) begin
      item.mode = (pick < 72) ? MODE_READ : MODE_WRITE;
      if ($urandom_range(99) < 85) item.address = ADDR_DIVIDER + 16'($urandom_range(3));
      if (item.mode == MODE_WRITE && item.address == ADDR_COUNTER && $urandom_range(1))
        item.write_data = 8'($urandom_range(8'hFF, 8'hF0));
      if (item.mode == MODE_WRITE && item.address == ADDR_CONTROL && $urandom_range(3) != 0)
        item.write_data[CTRL_RUN_BIT] = 1'b1;
    end else begin
      item.mode = MODE_UNUSED;
    end
    return item;
  endfunction

  task automatic add_row(input logic [1:0] mode, input logic [15:0] addr,
                         input logic [7:0] wdata, input logic [7:0] ticks,
                         input bit pinned, input logic [7:0] rd, input logic irq);
    stim_row_t row;
    row.item.mode = mode;
    row.item.address = addr;
    row.item.write_data = wdata;
    row.item.tick_count = ticks;
    row.pinned = pinned;
    row.res.read_data = rd;
    row.res.timer_interrupt = irq;
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input hct_in_t item, input bit pinned, input hct_out_t pinned_res);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    cur_pinned = pinned;
    cur_pinned_res = pinned_res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending until every outstanding result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Result side: random stall, changed only at the falling edge.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Check completed result transfers, then predict accepted input transfers.
  // Both in one block so the queue order never depends on process order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          mismatch_count++;
        end else begin
          want_res = pending_results.pop_front();
          if (out_data.read_data !== want_res.read_data) begin
            $display("%0t: read_data expected %h got %h",
                     $time, want_res.read_data, out_data.read_data);
            mismatch_count++;
          end
          if (out_data.timer_interrupt !== want_res.timer_interrupt) begin
            $display("%0t: timer_interrupt expected %b got %b",
                     $time, want_res.timer_interrupt, out_data.timer_interrupt);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        model_res = timer_predict(in_data);
        pending_results.push_back(cur_pinned ? cur_pinned_res : model_res);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    shadow_residue = '0;
    shadow_subcount = '0;
    shadow_prescale = '0;
    shadow_divider = '0;
    shadow_counter = '0;
    shadow_modulo = '0;
    shadow_control = '0;

    // Directed table. Pinned rows: state after reset, unmapped addresses,
    // write and unused-mode results, a modulo read-back.
    add_row(MODE_READ,   ADDR_DIVIDER, 8'hFF, 8'hFF, 1, 8'h00, 1'b0); // all zero after reset
    add_row(MODE_READ,   ADDR_COUNTER, 8'h00, 8'h00, 1, 8'h00, 1'b0);
    add_row(MODE_READ,   ADDR_CONTROL, 8'h00, 8'h00, 1, 8'h00, 1'b0);
    add_row(MODE_READ,   16'h0000,     8'h00, 8'h00, 1, 8'h00, 1'b0); // unmapped reads
    add_row(MODE_READ,   16'hFFFF,     8'h00, 8'h00, 1, 8'h00, 1'b0);
    add_row(MODE_READ,   16'hFF03,     8'h00, 8'h00, 1, 8'h00, 1'b0);
    add_row(MODE_READ,   16'hFF08,     8'h00, 8'h00, 1, 8'h00, 1'b0);
    add_row(MODE_WRITE,  ADDR_MODULO,  8'hFF, 8'hFF, 1, 8'h00, 1'b0);
    add_row(MODE_READ,   ADDR_MODULO,  8'h00, 8'h00, 1, 8'hFF, 1'b0);
    add_row(MODE_WRITE,  ADDR_CONTROL, 8'h05, 8'h00, 1, 8'h00, 1'b0); // run, threshold 1
    add_row(MODE_TICK,   16'hFFFF,     8'hFF, 8'h00, 0, 8'h00, 1'b0); // zero-cycle tick
    add_row(MODE_TICK,   ADDR_COUNTER, 8'hFF, 8'hFF, 0, 8'h00, 1'b0); // largest tick
    add_row(MODE_WRITE,  ADDR_COUNTER, 8'hFF, 8'h00, 1, 8'h00, 1'b0);
    add_row(MODE_TICK,   16'h0000,     8'h00, 8'h04, 0, 8'h00, 1'b0); // overflow, reload
    add_row(MODE_READ,   ADDR_COUNTER, 8'h00, 8'hFF, 0, 8'h00, 1'b0);
    add_row(MODE_WRITE,  ADDR_DIVIDER, 8'hAA, 8'h00, 1, 8'h00, 1'b0); // divider write
    add_row(MODE_READ,   ADDR_DIVIDER, 8'h00, 8'h00, 0, 8'h00, 1'b0);
    add_row(MODE_WRITE,  16'h0000,     8'hFF, 8'hFF, 1, 8'h00, 1'b0); // unmapped write
    add_row(MODE_UNUSED, 16'hFFFF,     8'hFF, 8'hFF, 1, 8'h00, 1'b0); // mode 3 no-op
    add_row(MODE_WRITE,  ADDR_CONTROL, 8'hFF, 8'h00, 1, 8'h00, 1'b0); // threshold 16
    add_row(MODE_TICK,   16'h0000,     8'h00, 8'hFF, 0, 8'h00, 1'b0);
    add_row(MODE_WRITE,  ADDR_CONTROL, 8'h04, 8'h00, 1, 8'h00, 1'b0); // threshold 64
    add_row(MODE_TICK,   16'h0000,     8'h00, 8'hFF, 0, 8'h00, 1'b0);
    add_row(MODE_WRITE,  ADDR_CONTROL, 8'h03, 8'h00, 1, 8'h00, 1'b0); // stopped
    add_row(MODE_TICK,   16'h0000,     8'h00, 8'hC8, 0, 8'h00, 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < directed_rows.size(); i++)
      send_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].res);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 1000 && i < 1300);   // back-to-back stretch on both sides
      if (i == 700 || i == 1500) drain_results();
      send_item(random_item(), 1'b0, '0);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
